// ----- src/mlc_pkg.sv -----
// Shared types and constants for the metrics LRU cache unit.
// No dependencies; every other file in src/ refers to it by scoped names.
package mlc_pkg;

    localparam int CAPACITY_DEF  = 32;
    localparam int PAYLOAD_W_DEF = 64;

    localparam int FIELD_W = 16;
    localparam int KEY_W   = 3 * FIELD_W;
    localparam int TICK_W  = 32;
    localparam int MAX_W   = 6;
    localparam int SLOT_W  = 5;
    localparam int OCC_W   = 6;

    localparam logic [MAX_W-1:0] MAX_ENTRIES_RST = 6'd32;

    // Register index as decoded from paddr[2].
    localparam logic REG_MAX_ENTRIES = 1'b0;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_FLUSH  = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_DECIDE,
        ST_SWEEP,
        ST_SWEEP_LAST,
        ST_RESP
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic take;
        logic scan_rd;
        logic sweep_rd;
        logic decide;
        logic finish;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic addr_last;
        logic need_sweep;
    } t_dp_status;

    // Result fields apart from the payload word.
    typedef struct packed {
        logic              hit;
        logic              evicted;
        logic [SLOT_W-1:0] slot;
        logic [OCC_W-1:0]  occupancy;
    } t_result;

endpackage

// ----- src/mlc_ctrl.sv -----
// Sequencing state machine of the metrics LRU cache unit.
// Depends on mlc_pkg for the state, command and status types.
module mlc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  mlc_pkg::t_cmd       i_cmd,
    input  logic                i_out_free,
    input  mlc_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output mlc_pkg::t_dp_cmd    o_ctl
);

    mlc_pkg::t_state r_state;
    mlc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mlc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mlc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_cmd inside {mlc_pkg::CMD_LOOKUP, mlc_pkg::CMD_INSERT}) begin
                        n_state = mlc_pkg::ST_SCAN;
                    end else begin
                        n_state = mlc_pkg::ST_DECIDE;
                    end
                end
            end
            mlc_pkg::ST_SCAN: begin
                if (i_status.addr_last) begin
                    n_state = mlc_pkg::ST_SCAN_LAST;
                end
            end
            mlc_pkg::ST_SCAN_LAST: begin
                n_state = mlc_pkg::ST_DECIDE;
            end
            mlc_pkg::ST_DECIDE: begin
                n_state = i_status.need_sweep ? mlc_pkg::ST_SWEEP : mlc_pkg::ST_RESP;
            end
            mlc_pkg::ST_SWEEP: begin
                if (i_status.addr_last) begin
                    n_state = mlc_pkg::ST_SWEEP_LAST;
                end
            end
            mlc_pkg::ST_SWEEP_LAST: begin
                n_state = mlc_pkg::ST_RESP;
            end
            mlc_pkg::ST_RESP: begin
                if (i_out_free) begin
                    n_state = mlc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mlc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            mlc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.take = i_in_valid;
            end
            mlc_pkg::ST_SCAN: begin
                o_ctl.scan_rd = 1'b1;
            end
            mlc_pkg::ST_SCAN_LAST: begin
                o_ctl = '0;
            end
            mlc_pkg::ST_DECIDE: begin
                o_ctl.decide = 1'b1;
            end
            mlc_pkg::ST_SWEEP: begin
                o_ctl.sweep_rd = 1'b1;
            end
            mlc_pkg::ST_SWEEP_LAST: begin
                o_ctl = '0;
            end
            mlc_pkg::ST_RESP: begin
                o_ctl.finish = i_out_free;
            end
            default: begin
                o_ctl = '0;
            end
        endcase
    end

endmodule

// ----- src/mlc_dpath.sv -----
// Datapath of the metrics LRU cache unit: entry memories, valid bits,
// scan trackers, rank sweep and result register. Depends on mlc_pkg.
module mlc_dpath #(
    parameter int CAPACITY      = mlc_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_WIDTH = mlc_pkg::PAYLOAD_W_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mlc_pkg::t_dp_cmd              i_ctl,
    input  mlc_pkg::t_cmd                 i_op,
    input  logic [mlc_pkg::FIELD_W-1:0]   i_family,
    input  logic [mlc_pkg::FIELD_W-1:0]   i_size,
    input  logic [mlc_pkg::FIELD_W-1:0]   i_style,
    input  logic [PAYLOAD_WIDTH-1:0]      i_payload,
    input  logic [mlc_pkg::TICK_W-1:0]    i_tick,
    input  logic [mlc_pkg::MAX_W-1:0]     i_max_entries,
    output mlc_pkg::t_dp_status           o_status,
    output mlc_pkg::t_result              o_res,
    output logic [PAYLOAD_WIDTH-1:0]      o_res_payload
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > mlc_pkg::MAX_W) ? CW : mlc_pkg::MAX_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

    // Entry memories
    logic [mlc_pkg::KEY_W-1:0]  m_key  [CAPACITY];
    logic [PAYLOAD_WIDTH-1:0]   m_pay  [CAPACITY];
    logic [mlc_pkg::TICK_W-1:0] m_ts   [CAPACITY];
    logic [IW-1:0]              m_rank [CAPACITY];

    logic [CAPACITY-1:0] r_valid;
    logic [CAPACITY-1:0] n_valid;
    logic [CW-1:0]       r_count;

    // Held item
    mlc_pkg::t_cmd              r_op;
    logic [mlc_pkg::KEY_W-1:0]  r_key;
    logic [PAYLOAD_WIDTH-1:0]   r_pay;
    logic [mlc_pkg::TICK_W-1:0] r_tick;

    // Read port and registered read data
    logic [IW-1:0]              r_addr;
    logic                       r_rd_vld;
    logic                       r_rd_sweep;
    logic [IW-1:0]              r_rd_idx;
    logic [mlc_pkg::KEY_W-1:0]  r_key_q;
    logic [PAYLOAD_WIDTH-1:0]   r_pay_q;
    logic [mlc_pkg::TICK_W-1:0] r_ts_q;
    logic [IW-1:0]              r_rank_q;
    logic                       r_vld_q;

    // Scan trackers: first match, LRU victim, first free slot
    logic                       r_m_found;
    logic [IW-1:0]              r_m_idx;
    logic [IW-1:0]              r_m_rank;
    logic [PAYLOAD_WIDTH-1:0]   r_m_pay;
    logic                       r_v_found;
    logic [IW-1:0]              r_v_idx;
    logic [mlc_pkg::TICK_W-1:0] r_v_ts;
    logic [IW-1:0]              r_v_rank;
    logic                       r_f_found;
    logic [IW-1:0]              r_f_idx;

    // Sweep settings
    logic [IW-1:0] r_sw_slot;
    logic          r_sw_all;
    logic [IW-1:0] r_sw_thr;
    logic          r_sw_dec;
    logic [IW-1:0] r_sw_vr;

    mlc_pkg::t_result         r_res;
    logic [PAYLOAD_WIDTH-1:0] r_res_pay;

    logic rd_en;
    logic scan_cmp;
    logic hit_now;
    logic vic_now;

    logic [LW-1:0] max_ext;
    logic [LW-1:0] lim;
    logic          full;

    logic                     d_ev;
    logic                     d_has;
    logic                     d_ts_only;
    logic [IW-1:0]            d_slot;
    logic [CW-1:0]            d_count;
    mlc_pkg::t_result         d_res;
    logic [PAYLOAD_WIDTH-1:0] d_res_pay;

    logic          sw_upd;
    logic          sw_inc;
    logic          sw_dec;
    logic [IW-1:0] sw_rank;

    logic          rk_we;
    logic [IW-1:0] rk_wa;
    logic [IW-1:0] rk_wd;

    assign rd_en    = i_ctl.scan_rd | i_ctl.sweep_rd;
    assign scan_cmp = r_rd_vld & ~r_rd_sweep;

    assign hit_now = r_vld_q && (r_key_q == r_key);
    assign vic_now = r_vld_q && (!r_v_found || (r_ts_q < r_v_ts) ||
                     ((r_ts_q == r_v_ts) && (r_rank_q < r_v_rank)));

    // Effective limit: zero acts as one, clamp to capacity
    always_comb begin
        max_ext = LW'(i_max_entries);
        if (max_ext == '0) begin
            lim = LW'(1);
        end else if (max_ext > LW'(CAPACITY)) begin
            lim = LW'(CAPACITY);
        end else begin
            lim = max_ext;
        end
        full = LW'(r_count) >= lim;
    end

    always_comb begin
        d_ev      = 1'b0;
        d_has     = 1'b0;
        d_ts_only = 1'b0;
        d_slot    = r_m_idx;
        d_count   = r_count;
        d_res     = '0;
        d_res_pay = '0;
        unique case (r_op)
            mlc_pkg::CMD_LOOKUP: begin
                if (r_m_found) begin
                    d_ts_only     = 1'b1;
                    d_res.hit     = 1'b1;
                    d_res.slot    = mlc_pkg::SLOT_W'(r_m_idx);
                    d_res_pay     = r_m_pay;
                end
            end
            mlc_pkg::CMD_INSERT: begin
                if (r_m_found) begin
                    d_has = 1'b1;
                end else begin
                    d_ev = full & r_v_found;
                    if (r_f_found) begin
                        d_has  = 1'b1;
                        d_slot = (d_ev && (r_v_idx < r_f_idx)) ? r_v_idx : r_f_idx;
                    end else if (d_ev) begin
                        d_has  = 1'b1;
                        d_slot = r_v_idx;
                    end
                    d_count = r_count - CW'(d_ev) + CW'(d_has);
                end
                d_res.evicted = d_ev;
                if (d_has) begin
                    d_res.slot = mlc_pkg::SLOT_W'(d_slot);
                end
            end
            mlc_pkg::CMD_FLUSH: begin
                d_count = '0;
            end
            mlc_pkg::CMD_NOP: begin
                d_count = r_count;
            end
            default: begin
                d_count = r_count;
            end
        endcase
        d_res.occupancy = mlc_pkg::OCC_W'(d_count);
    end

    assign o_status.addr_last  = (r_addr == LAST_IDX);
    assign o_status.need_sweep = (r_op == mlc_pkg::CMD_INSERT) && d_has;

    // Sweep: newer entries move back, ranks above the victim close the gap
    always_comb begin
        sw_upd  = r_rd_vld && r_rd_sweep && r_valid[r_rd_idx] && (r_rd_idx != r_sw_slot);
        sw_inc  = r_sw_all || (r_rank_q < r_sw_thr);
        sw_dec  = r_sw_dec && (r_rank_q > r_sw_vr);
        sw_rank = r_rank_q + IW'(sw_inc) - IW'(sw_dec);
    end

    always_comb begin
        rk_we = 1'b0;
        rk_wa = r_rd_idx;
        rk_wd = sw_rank;
        if (i_ctl.decide && o_status.need_sweep) begin
            rk_we = 1'b1;
            rk_wa = d_slot;
            rk_wd = '0;
        end else if (sw_upd) begin
            rk_we = 1'b1;
        end
    end

    // Memory writes
    always_ff @(posedge i_clk) begin
        if (i_ctl.decide && o_status.need_sweep) begin
            m_key[d_slot] <= r_key;
            m_pay[d_slot] <= r_pay;
        end
        if (i_ctl.decide && (o_status.need_sweep || d_ts_only)) begin
            m_ts[d_slot] <= r_tick;
        end
        if (rk_we) begin
            m_rank[rk_wa] <= rk_wd;
        end
    end

    // Memory reads, registered
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_key_q  <= m_key[r_addr];
            r_pay_q  <= m_pay[r_addr];
            r_ts_q   <= m_ts[r_addr];
            r_rank_q <= m_rank[r_addr];
            r_vld_q  <= r_valid[r_addr];
            r_rd_idx <= r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_rd_sweep <= 1'b0;
            r_addr     <= '0;
        end else begin
            r_rd_vld   <= rd_en;
            r_rd_sweep <= i_ctl.sweep_rd;
            if (i_ctl.take || i_ctl.decide) begin
                r_addr <= '0;
            end else if (rd_en) begin
                r_addr <= (r_addr == LAST_IDX) ? '0 : r_addr + IW'(1);
            end
        end
    end

    // Hold the item
    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_op   <= i_op;
            r_key  <= {i_style, i_size, i_family};
            r_pay  <= i_payload;
            r_tick <= i_tick;
        end
    end

    // Scan trackers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_found <= 1'b0;
            r_v_found <= 1'b0;
            r_f_found <= 1'b0;
        end else if (i_ctl.take) begin
            r_m_found <= 1'b0;
            r_v_found <= 1'b0;
            r_f_found <= 1'b0;
        end else if (scan_cmp) begin
            if (hit_now && !r_m_found) begin
                r_m_found <= 1'b1;
                r_m_idx   <= r_rd_idx;
                r_m_rank  <= r_rank_q;
                r_m_pay   <= r_pay_q;
            end
            if (vic_now) begin
                r_v_found <= 1'b1;
                r_v_idx   <= r_rd_idx;
                r_v_ts    <= r_ts_q;
                r_v_rank  <= r_rank_q;
            end
            if (!r_vld_q && !r_f_found) begin
                r_f_found <= 1'b1;
                r_f_idx   <= r_rd_idx;
            end
        end
    end

    // Valid bits and occupancy: a flush clears all; else drop the victim, then mark the written slot
    always_comb begin
        n_valid = r_valid;
        if (r_op == mlc_pkg::CMD_FLUSH) begin
            n_valid = '0;
        end else begin
            if (d_ev) begin
                n_valid[r_v_idx] = 1'b0;
            end
            if (o_status.need_sweep) begin
                n_valid[d_slot] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_ctl.decide) begin
            r_count <= d_count;
            r_valid <= n_valid;
        end
    end

    // Sweep settings and result
    always_ff @(posedge i_clk) begin
        if (i_ctl.decide) begin
            r_sw_slot <= d_slot;
            r_sw_all  <= ~r_m_found;
            r_sw_thr  <= r_m_rank;
            r_sw_dec  <= d_ev;
            r_sw_vr   <= r_v_rank;
            r_res     <= d_res;
            r_res_pay <= d_res_pay;
        end
    end

    assign o_res         = r_res;
    assign o_res_payload = r_res_pay;

endmodule

// ----- src/metrics_lru_cache_unit.sv -----
// Top level of the metrics LRU cache unit: stream ports, APB register,
// output register. Instantiates mlc_ctrl and mlc_dpath; depends on mlc_pkg.
//
//  channel   direction  handshake                       payload
//  --------  ---------  ------------------------------  ------------------------------
//  s_axis    in         s_axis_tvalid / s_axis_tready   tuser: command; tdata: key,
//                                                       payload, tick
//  m_axis    out        m_axis_tvalid / m_axis_tready   tuser: hit, evicted; tdata:
//                                                       slot, payload, occupancy
//  apb       in         psel & penable & pwrite         max_entries at byte 0
//
// One item at a time. A lookup scans every entry before its result is
// ready (one registered memory read per entry in the scan). An insert that
// writes an entry makes the scan, then a second pass over the rank memory.
// Flush and the unused command skip both passes.
// Reset is synchronous and clears valid bits and occupancy at once, no
// clearing pass. The output register holds a result until it is taken;
// s_axis_tready stays low until the result has moved into it.
module metrics_lru_cache_unit #(
    parameter int CAPACITY      = mlc_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_WIDTH = mlc_pkg::PAYLOAD_W_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [15:0] family_id, [31:16] point_size, [47:32] style_bits,
    // then payload_in (PAYLOAD_WIDTH), then now_tick (32), zero fill
    input  logic [((80+PAYLOAD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // [1:0] command
    input  logic [1:0]                            s_axis_tuser,

    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [4:0] slot, then payload_out (PAYLOAD_WIDTH), then occupancy (6), zero fill
    output logic [((11+PAYLOAD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // [0] hit, [1] evicted
    output logic [1:0]                            m_axis_tuser,

    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    localparam int OUT_DW  = ((11 + PAYLOAD_WIDTH + 7) / 8) * 8;
    localparam int PAY_LSB = 3 * mlc_pkg::FIELD_W;
    localparam int TICK_LSB = PAY_LSB + PAYLOAD_WIDTH;
    localparam int OUT_PAY_LSB = mlc_pkg::SLOT_W;
    localparam int OUT_OCC_LSB = OUT_PAY_LSB + PAYLOAD_WIDTH;

    logic [mlc_pkg::MAX_W-1:0] r_max_entries;

    logic              r_out_vld;
    logic              n_out_vld;
    logic [OUT_DW-1:0] r_out_tdata;
    logic [OUT_DW-1:0] n_out_tdata;
    logic [1:0]        r_out_tuser;

    logic                     out_free;
    mlc_pkg::t_dp_cmd         ctl;
    mlc_pkg::t_dp_status      status;
    mlc_pkg::t_result         res;
    logic [PAYLOAD_WIDTH-1:0] res_pay;
    mlc_pkg::t_cmd            in_cmd;

    // Configuration register: write on the access phase
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= mlc_pkg::MAX_ENTRIES_RST;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == mlc_pkg::REG_MAX_ENTRIES)) begin
            r_max_entries <= pwdata[mlc_pkg::MAX_W-1:0];
        end
    end

    assign prdata = (paddr[2] == mlc_pkg::REG_MAX_ENTRIES) ?
                    32'(r_max_entries) : '0;

    assign in_cmd   = mlc_pkg::t_cmd'(s_axis_tuser);
    assign out_free = ~r_out_vld | m_axis_tready;

    mlc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_cmd      (in_cmd),
        .i_out_free (out_free),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_ctl      (ctl)
    );

    mlc_dpath #(
        .CAPACITY      (CAPACITY),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_op          (in_cmd),
        .i_family      (s_axis_tdata[mlc_pkg::FIELD_W-1:0]),
        .i_size        (s_axis_tdata[mlc_pkg::FIELD_W +: mlc_pkg::FIELD_W]),
        .i_style       (s_axis_tdata[2*mlc_pkg::FIELD_W +: mlc_pkg::FIELD_W]),
        .i_payload     (s_axis_tdata[PAY_LSB +: PAYLOAD_WIDTH]),
        .i_tick        (s_axis_tdata[TICK_LSB +: mlc_pkg::TICK_W]),
        .i_max_entries (r_max_entries),
        .o_status      (status),
        .o_res         (res),
        .o_res_payload (res_pay)
    );

    // Pack the result; padding bits stay zero
    always_comb begin
        n_out_tdata = '0;
        n_out_tdata[mlc_pkg::SLOT_W-1:0] = res.slot;
        n_out_tdata[OUT_PAY_LSB +: PAYLOAD_WIDTH] = res_pay;
        n_out_tdata[OUT_OCC_LSB +: mlc_pkg::OCC_W] = res.occupancy;
    end

    // Output register: load on finish, drop once transferred
    always_comb begin
        n_out_vld = r_out_vld;
        if (ctl.finish) begin
            n_out_vld = 1'b1;
        end else if (m_axis_tready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.finish) begin
            r_out_tdata <= n_out_tdata;
            r_out_tuser <= {res.evicted, res.hit};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for metrics_lru_cache_unit: lookups, inserts, flushes and the
// max_entries register, predicted in-bench and compared on every result transfer.
// Depends on mlc_pkg and the RTL under src/ only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP        = mlc_pkg::CAPACITY_DEF;
    localparam int PW         = mlc_pkg::PAYLOAD_W_DEF;
    localparam int TW         = mlc_pkg::TICK_W;
    localparam int SW         = mlc_pkg::SLOT_W;
    localparam int OW         = mlc_pkg::OCC_W;
    localparam int MW         = mlc_pkg::MAX_W;
    localparam int S_DATA_W   = ((80 + PW + 7) / 8) * 8;
    localparam int M_DATA_W   = ((11 + PW + 7) / 8) * 8;
    // slowest item: an insert with the second pass over the rank memory
    localparam int INSERT_LAT = 2 * CAP + 5;
    localparam int CYCLE_CAP  = 1_500_000;
    localparam int POOL_N     = 48;
    localparam int LONG_HOLD  = 400;
    localparam logic [2:0] ADDR_MAX_ENTRIES = {mlc_pkg::REG_MAX_ENTRIES, 2'b00};

    typedef struct packed {
        mlc_pkg::t_cmd     cmd;
        logic [15:0]       family;
        logic [15:0]       point_size;
        logic [15:0]       style;
        logic [PW-1:0]     payload;
        logic [TW-1:0]     tick;
    } t_cache_item;

    typedef struct packed {
        logic              hit;
        logic              evicted;
        logic [SW-1:0]     slot;
        logic [PW-1:0]     payload;
        logic [OW-1:0]     occupancy;
    } t_cache_result;

    // ------------------------------------------------------------------
    // DUT signals: every input starts at a known value
    // ------------------------------------------------------------------
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic [1:0]          s_axis_tuser = mlc_pkg::CMD_LOOKUP;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [1:0]          m_axis_tuser;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    metrics_lru_cache_unit #(
        .CAPACITY      (CAP),
        .PAYLOAD_WIDTH (PW)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // [15:0] family_id, [31:16] point_size, [47:32] style_bits,
        // [111:48] payload_in, [143:112] now_tick
        .s_axis_tdata  (s_axis_tdata),
        // [1:0] command
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [4:0] slot, [68:5] payload_out, [74:69] occupancy, zero fill above
        .m_axis_tdata  (m_axis_tdata),
        // [0] hit, [1] evicted
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_cache_result pending_results[$];   // predicted results, oldest first
    int            error_count   = 0;
    int            items_sent    = 0;
    int            results_seen  = 0;
    int            hits_seen     = 0;
    int            evicts_seen   = 0;
    int            limit_writes  = 0;
    int            long_holds    = 0;
    int            hold_request  = 0;    // cycles of output stall asked of the sink
    bit            calm          = 1'b0; // no idling on either side when set
    longint        cycle_count   = 0;

    // Shadow copy of the cache, kept in step with every accepted transfer
    logic              shadow_valid   [CAP];
    logic [15:0]       shadow_family  [CAP];
    logic [15:0]       shadow_size    [CAP];
    logic [15:0]       shadow_style   [CAP];
    logic [PW-1:0]     shadow_payload [CAP];
    logic [TW-1:0]     shadow_stamp   [CAP];
    int unsigned       shadow_rank    [CAP];
    int unsigned       shadow_count;
    logic [MW-1:0]     shadow_limit;

    // Random traffic draws keys from this pool so that hits and evictions happen
    logic [47:0]       key_pool [POOL_N];
    int                pool_span = POOL_N;
    logic [TW-1:0]     tick_now  = '0;

    // ------------------------------------------------------------------
    // Clock and run-length guard
    // ------------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("%0t: timed out with %0d results outstanding", $time,
                     pending_results.size());
            $display("FAIL metrics_lru_cache_unit");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Cache predictor
    // ------------------------------------------------------------------
    function automatic int find_entry(input logic [15:0] fam, input logic [15:0] psz,
                                      input logic [15:0] sty);
        for (int i = 0; i < CAP; i++) begin
            if (shadow_valid[i] && shadow_family[i] == fam && shadow_size[i] == psz &&
                shadow_style[i] == sty)
                return i;
        end
        return -1;
    endfunction

    // Make slot v the newest insert; entries newer than its old rank age by one.
    function automatic void make_newest(input int v, input int unsigned old_rank);
        for (int i = 0; i < CAP; i++) begin
            if (shadow_valid[i] && i != v && shadow_rank[i] < old_rank)
                shadow_rank[i]++;
        end
        shadow_rank[v] = 0;
    endfunction

    function automatic t_cache_result predict_cache(input t_cache_item it);
        t_cache_result r;
        int            v;
        int            vic;
        int unsigned   lim;
        int unsigned   vic_rank;
        r = '0;
        case (it.cmd)
            mlc_pkg::CMD_LOOKUP: begin
                v = find_entry(it.family, it.point_size, it.style);
                if (v >= 0) begin
                    shadow_stamp[v] = it.tick;
                    r.hit     = 1'b1;
                    r.slot    = SW'(v);
                    r.payload = shadow_payload[v];
                end
            end
            mlc_pkg::CMD_INSERT: begin
                // zero acts as one, anything past the capacity as the capacity
                lim = 32'(shadow_limit);
                if (lim == 0)
                    lim = 1;
                if (lim > CAP)
                    lim = CAP;
                v = find_entry(it.family, it.point_size, it.style);
                if (v >= 0) begin
                    make_newest(v, shadow_rank[v]);
                end else begin
                    if (shadow_count >= lim) begin
                        // oldest stamp goes; on a tie the newest insert goes
                        vic = -1;
                        for (int i = 0; i < CAP; i++) begin
                            if (shadow_valid[i] &&
                                (vic < 0 || shadow_stamp[i] < shadow_stamp[vic] ||
                                 (shadow_stamp[i] == shadow_stamp[vic] &&
                                  shadow_rank[i] < shadow_rank[vic])))
                                vic = i;
                        end
                        if (vic >= 0) begin
                            vic_rank = shadow_rank[vic];
                            shadow_valid[vic] = 1'b0;
                            for (int i = 0; i < CAP; i++) begin
                                if (shadow_valid[i] && shadow_rank[i] > vic_rank)
                                    shadow_rank[i]--;
                            end
                            shadow_count--;
                            r.evicted = 1'b1;
                        end
                    end
                    for (int i = 0; i < CAP; i++) begin
                        if (!shadow_valid[i]) begin
                            v = i;
                            break;
                        end
                    end
                    if (v >= 0) begin
                        make_newest(v, 32'hFFFF_FFFF);
                        shadow_valid[v] = 1'b1;
                        shadow_count++;
                    end
                end
                if (v >= 0) begin
                    shadow_family[v]  = it.family;
                    shadow_size[v]    = it.point_size;
                    shadow_style[v]   = it.style;
                    shadow_payload[v] = it.payload;
                    shadow_stamp[v]   = it.tick;
                    r.slot            = SW'(v);
                end
            end
            mlc_pkg::CMD_FLUSH: begin
                for (int i = 0; i < CAP; i++)
                    shadow_valid[i] = 1'b0;
                shadow_count = 0;
            end
            default: ;
        endcase
        r.occupancy = OW'(shadow_count);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Item construction
    // ------------------------------------------------------------------
    function automatic t_cache_item make_item(input mlc_pkg::t_cmd cmd,
                                              input logic [15:0] fam,
                                              input logic [15:0] psz,
                                              input logic [15:0] sty,
                                              input logic [PW-1:0] pay,
                                              input logic [TW-1:0] tck);
        t_cache_item it;
        it.cmd        = cmd;
        it.family     = fam;
        it.point_size = psz;
        it.style      = sty;
        it.payload    = pay;
        it.tick       = tck;
        return it;
    endfunction

    function automatic t_cache_item random_item();
        t_cache_item it;
        int          pick;
        logic [47:0] key;
        pick = $urandom_range(0, 99);
        if (pick < 47)
            it.cmd = mlc_pkg::CMD_LOOKUP;
        else if (pick < 97)
            it.cmd = mlc_pkg::CMD_INSERT;
        else if (pick < 98)
            it.cmd = mlc_pkg::CMD_FLUSH;
        else
            it.cmd = mlc_pkg::CMD_NOP;
        // mostly pool keys; now and then a stray key that can only miss
        if ($urandom_range(0, 19) == 0)
            key = 48'({$urandom, $urandom});
        else
            key = key_pool[$urandom_range(0, pool_span - 1)];
        it.family     = key[15:0];
        it.point_size = key[31:16];
        it.style      = key[47:32];
        it.payload    = PW'({$urandom, $urandom});
        // slow clock with ties, and the odd jump anywhere in the range
        if ($urandom_range(0, 29) == 0)
            tick_now = $urandom;
        else
            tick_now = tick_now + $urandom_range(0, 2);
        it.tick = tick_now;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------
    // Offer one item; called at a rising edge, returns at the edge of its transfer.
    task automatic send_item(input t_cache_item it);
        logic [S_DATA_W-1:0] word;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        word                       = '0;
        word[15:0]                 = it.family;
        word[31:16]                = it.point_size;
        word[47:32]                = it.style;
        word[48 +: PW]             = it.payload;
        word[48 + PW +: TW]        = it.tick;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= it.cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(predict_cache(it));
        items_sent++;
    endtask

    // Drop the input and hold until every predicted result has been taken.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write max_entries while idle and read it back.
    task automatic write_limit(input logic [MW-1:0] value);
        logic [31:0] rd;
        drain_results();
        apb_access(1'b1, ADDR_MAX_ENTRIES, 32'(value), rd);
        shadow_limit = value;
        limit_writes++;
        @(posedge i_clk);
        apb_access(1'b0, ADDR_MAX_ENTRIES, '0, rd);
        if (rd !== 32'(value)) begin
            $display("%0t: max_entries read back: expected %h actual %h", $time,
                     32'(value), rd);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result sink: random stalls, long hold-offs on request, none when calm
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_request > 0) begin
                // count the long hold here, not in the test
                stall_left   = hold_request - 1;
                hold_request = 0;
                long_holds++;
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every result transfer against the oldest prediction
    // ------------------------------------------------------------------
    task automatic report_field(input string name, input logic [PW-1:0] want,
                                input logic [PW-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_cache_result want;
        if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            results_seen++;
            hits_seen   += int'(m_axis_tuser[0]);
            evicts_seen += int'(m_axis_tuser[1]);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none actual %h/%h", $time,
                         m_axis_tuser, m_axis_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                report_field("hit", PW'(want.hit), PW'(m_axis_tuser[0]));
                report_field("evicted", PW'(want.evicted), PW'(m_axis_tuser[1]));
                report_field("slot", PW'(want.slot), PW'(m_axis_tdata[SW-1:0]));
                report_field("payload_out", want.payload, m_axis_tdata[SW +: PW]);
                report_field("occupancy", PW'(want.occupancy),
                             PW'(m_axis_tdata[SW + PW +: OW]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Empty cache, unused command, field extremes, overwrite in place, flush.
    task automatic test_basic_ops();
        send_item(make_item(mlc_pkg::CMD_LOOKUP, 16'h0000, 16'h0000, 16'h0000, '0, '0));
        send_item(make_item(mlc_pkg::CMD_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1, '1));
        send_item(make_item(mlc_pkg::CMD_INSERT, 16'h7FFF, 16'h8000, 16'hFFFF, '1, '1));
        send_item(make_item(mlc_pkg::CMD_INSERT, 16'h0000, 16'h0000, 16'h0000, '0, '0));
        send_item(make_item(mlc_pkg::CMD_LOOKUP, 16'h7FFF, 16'h8000, 16'hFFFF, '0,
                            32'd3));
        // one field off by a bit must miss
        send_item(make_item(mlc_pkg::CMD_LOOKUP, 16'h7FFF, 16'h8000, 16'hFFFE, '0,
                            32'd4));
        send_item(make_item(mlc_pkg::CMD_INSERT, 16'h7FFF, 16'h8000, 16'hFFFF,
                            PW'(64'h0123_4567_89AB_CDEF), 32'd5));
        send_item(make_item(mlc_pkg::CMD_LOOKUP, 16'h7FFF, 16'h8000, 16'hFFFF, '0,
                            32'd6));
        send_item(make_item(mlc_pkg::CMD_NOP, 16'h0000, 16'h0000, 16'h0000, '0, '0));
        send_item(make_item(mlc_pkg::CMD_FLUSH, 16'h8000, 16'h7FFF, 16'h0001, '1,
                            32'd7));
        send_item(make_item(mlc_pkg::CMD_LOOKUP, 16'h7FFF, 16'h8000, 16'hFFFF, '0,
                            32'd8));
    endtask

    // Victim choice: oldest stamp, newest insert among equal stamps.
    task automatic test_eviction_order();
        write_limit(6'd2);
        send_item(make_item(mlc_pkg::CMD_INSERT, 16'd1, 16'd12, 16'd0, PW'(64'hA1),
                            32'd10));
        send_item(make_item(mlc_pkg::CMD_INSERT, 16'd2, 16'd12, 16'd0, PW'(64'hA2),
                            32'd10));
        send_item(make_item(mlc_pkg::CMD_INSERT, 16'd3, 16'd12, 16'd0, PW'(64'hA3),
                            32'd11));
        send_item(make_item(mlc_pkg::CMD_LOOKUP, 16'd2, 16'd12, 16'd0, '0, 32'd12));
        send_item(make_item(mlc_pkg::CMD_LOOKUP, 16'd1, 16'd12, 16'd0, '0, 32'd20));
        send_item(make_item(mlc_pkg::CMD_INSERT, 16'd4, 16'd12, 16'd0, PW'(64'hA4),
                            32'd12));
        send_item(make_item(mlc_pkg::CMD_LOOKUP, 16'd3, 16'd12, 16'd0, '0, 32'd21));
    endtask

    // Limit lowered without a flush, zero limit, limit above the capacity.
    task automatic test_limit_edges();
        write_limit(6'd1);
        send_item(make_item(mlc_pkg::CMD_INSERT, 16'd5, 16'd9, 16'd1, PW'(64'hB5),
                            32'd30));
        write_limit(6'd0);
        send_item(make_item(mlc_pkg::CMD_INSERT, 16'd6, 16'd9, 16'd1, PW'(64'hB6),
                            32'd31));
        write_limit(6'd63);
        send_item(make_item(mlc_pkg::CMD_INSERT, 16'd7, 16'd9, 16'd1, PW'(64'hB7),
                            32'd32));
        send_item(make_item(mlc_pkg::CMD_INSERT, 16'd8, 16'd9, 16'd1, PW'(64'hB8),
                            32'd33));
        send_item(make_item(mlc_pkg::CMD_FLUSH, '0, '0, '0, '0, '0));
    endtask

    // Hold the result channel off while items keep coming, so the input stalls.
    task automatic test_output_stall();
        drain_results();
        hold_request = LONG_HOLD;
        repeat (6) send_item(random_item());
        drain_results();
    endtask

    // Random traffic across a spread of limits, each phase ending drained.
    task automatic test_random_traffic();
        logic [MW-1:0] limits [8];
        int            eff;
        limits = '{6'd32, 6'd4, 6'd1, 6'd0, 6'd63, 6'd17, 6'd8, 6'd2};
        key_pool[0] = {16'hFFFF, 16'h8000, 16'h7FFF};
        key_pool[1] = '0;
        for (int k = 2; k < POOL_N; k++)
            key_pool[k] = 48'({$urandom, $urandom});
        tick_now = $urandom;
        for (int p = 0; p < 8; p++) begin
            write_limit(limits[p]);
            // flush after some writes; leave the others lowered over a full cache
            if (p % 2 == 0)
                send_item(make_item(mlc_pkg::CMD_FLUSH, '0, '0, '0, '0, tick_now));
            eff       = (limits[p] == 0) ? 1 : (int'(limits[p]) > CAP) ? CAP :
                        int'(limits[p]);
            pool_span = (eff + 8 > POOL_N) ? POOL_N : eff + 8;
            for (int n = 0; n < 175; n++) begin
                if (p == 7 && n == 90)
                    calm = 1'b1;
                send_item(random_item());
            end
            if (p == 3)
                test_output_stall();
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin : run
        for (int i = 0; i < CAP; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_rank[i]  = 0;
        end
        shadow_count = 0;
        shadow_limit = mlc_pkg::MAX_ENTRIES_RST;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_eviction_order();
        test_limit_edges();
        test_random_traffic();

        // allow a stray result time to show, then settle the verdict
        drain_results();
        repeat (INSERT_LAT) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            error_count++;
        end

        $display("Covered %0d transfers in and %0d out: %0d hits, %0d evictions,",
                 items_sent, results_seen, hits_seen, evicts_seen);
        $display("%0d max_entries writes, %0d long output stall(s), %0d errors",
                 limit_writes, long_holds, error_count);
        if (error_count == 0)
            $display("PASS metrics_lru_cache_unit");
        else
            $display("FAIL metrics_lru_cache_unit");
        $finish;
    end

endmodule
